// ===== design/pis_pkg.sv =====
package pis_pkg;

	localparam int LEN_W         = 8;
	localparam int THR_W         = 17;
	localparam int SAMPLE_W      = 24;
	localparam int FILT_W        = 26;
	localparam int NOISE_W       = 34;
	localparam int SUM_W         = 32;
	localparam int DIV_W         = SUM_W + 8;
	localparam int TDATA_IN_W    = 24;
	localparam int TDATA_OUT_W   = 32;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = THR_W;

	localparam int MAX_PERIOD_DEF  = 128;
	localparam int NUM_PERIODS_DEF = 4;

	localparam logic [LEN_W-1:0] PLEN_RST = LEN_W'(20);
	localparam logic [THR_W-1:0] THR_RST  = THR_W'(100);

	localparam logic [CFG_IDX_W-1:0] REG_PERIOD_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'b1;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_REINIT = 1'b1;

	typedef struct packed {
		logic take;
		logic mul;
		logic fill;
		logic fill_zero;
		logic reinit;
		logic upd;
		logic noise_start;
		logic noise_wr;
		logic rs_clr;
		logic rs_add;
		logic use_j;
		logic lc_upd;
		logic av_add;
		logic ref_wr;
		logic set_lin;
		logic out_load;
		logic i_clr;
		logic i_inc;
		logic j_clr;
		logic j_inc;
		logic k_inc;
		logic phase_wrap;
	} cmd_t;

	typedef struct packed {
		logic kind;
		logic rs_pend;
		logic div_busy;
		logic k_last;
		logic i_last;
		logic j_last;
		logic period_end;
		logic spread_bad;
		logic out_free;
	} sts_t;

endpackage

// ===== design/pis_ram.sv =====
module pis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/pis_div.sv =====
module pis_div import pis_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_W-1:0]  num,
	input  logic [LEN_W-1:0]  den,
	output logic              busy,
	output logic [DIV_W-1:0]  quo
);

	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic [LEN_W-1:0] den_q;
	logic [LEN_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [LEN_W:0]   trial;
	logic             fits;

	assign trial = {rem_q[LEN_W-1:0], quo_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(DIV_W);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			den_q <= den;
			rem_q <= '0;
			quo_q <= num;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? (trial - {1'b0, den_q}) : trial;
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign busy = cnt_q != '0;
	assign quo  = quo_q;

endmodule

// ===== design/pis_dp.sv =====
module pis_dp import pis_pkg::*; #(
	parameter int MAX_PERIOD  = MAX_PERIOD_DEF,
	parameter int NUM_PERIODS = NUM_PERIODS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	output sts_t                    sts,
	input  logic [TDATA_IN_W-1:0]   s_axis_tdata,
	input  logic [0:0]              s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [TDATA_OUT_W-1:0]  m_axis_tdata,
	output logic [0:0]              m_axis_tuser,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	localparam int PW    = $clog2(MAX_PERIOD);
	localparam int SW    = $clog2(NUM_PERIODS);
	localparam int HD    = NUM_PERIODS * MAX_PERIOD;
	localparam int HAW   = $clog2(HD);
	localparam int ACC_W = NOISE_W + $clog2(NUM_PERIODS);
	localparam int AV_SH = $clog2(NUM_PERIODS);
	localparam int CW    = ((PW > LEN_W) ? PW : LEN_W) + 1;
	localparam logic [HAW-1:0] MAXP_A = HAW'(MAX_PERIOD);

	logic [LEN_W-1:0]           period_len_q;
	logic [THR_W-1:0]           thr_q;
	logic                       rs_pend_q;
	logic signed [SAMPLE_W-1:0] s_q;
	logic                       kind_q;
	logic [PW-1:0]              p_q;
	logic [PW-1:0]              phase_q;
	logic [SW-1:0]              slot_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic signed [SUM_W:0]      prod_q;
	logic                       neg_q;
	logic signed [SAMPLE_W-1:0] mx_q;
	logic signed [SAMPLE_W-1:0] mn_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic                       lin_q;
	logic [SW-1:0]              i_q;
	logic [PW-1:0]              j_q;
	logic [HAW-1:0]             k_q;
	logic [FILT_W-1:0]          filt_q;
	logic                       olin_q;
	logic                       ovalid_q;

	logic [LEN_W-1:0]           len;
	logic [HAW-1:0]             rd_ij;
	logic [HAW-1:0]             wr_sp;
	logic                       k_low;
	logic [SAMPLE_W-1:0]        fval;
	logic [SAMPLE_W-1:0]        recent_rd;
	logic [SAMPLE_W-1:0]        sample_rd;
	logic [NOISE_W-1:0]         noise_rd;
	logic [NOISE_W-1:0]         ref_rd;
	logic signed [SUM_W+1:0]    diff;
	logic [SUM_W+1:0]           diff_mag;
	logic [ACC_W-1:0]           acc_mag;
	logic [ACC_W-1:0]           av_mag;
	logic [NOISE_W-1:0]         av_val;
	logic                       div_start;
	logic [DIV_W-1:0]           div_num;
	logic [LEN_W-1:0]           div_den;
	logic                       div_busy;
	logic [DIV_W-1:0]           div_q;
	logic [NOISE_W-1:0]         qval;
	logic signed [SAMPLE_W-1:0] v;
	logic signed [SAMPLE_W-1:0] nmx;
	logic signed [SAMPLE_W-1:0] nmn;
	logic signed [SAMPLE_W:0]   spread;
	logic signed [NOISE_W-1:0]  ref_sh;
	logic signed [FILT_W:0]     filt;

	always_comb begin
		if (period_len_q < LEN_W'(2)) begin
			len = LEN_W'(2);
		end else if (int'(period_len_q) > MAX_PERIOD) begin
			len = LEN_W'(MAX_PERIOD);
		end else begin
			len = period_len_q;
		end
	end

	assign rd_ij = HAW'(i_q) * MAXP_A + HAW'(j_q);
	assign wr_sp = HAW'(slot_q) * MAXP_A + HAW'(p_q);
	assign k_low = k_q < MAXP_A;
	assign fval  = cmd.fill_zero ? '0 : s_q;

	assign diff     = SUM_W'(0) + (SUM_W+2)'(prod_q) - (SUM_W+2)'(sum_q);
	assign diff_mag = diff[SUM_W+1] ? (~diff + 1'b1) : diff;
	assign acc_mag  = acc_q[ACC_W-1] ? (~acc_q + 1'b1) : acc_q;

	// average of the periods, truncated toward zero
	assign av_mag = acc_mag >> AV_SH;
	assign av_val = NOISE_W'(acc_q[ACC_W-1] ? (~av_mag + 1'b1) : av_mag);

	assign div_start = cmd.noise_start;
	assign div_num   = {diff_mag[SUM_W-1:0], 8'h00};
	assign div_den   = len;
	assign qval      = NOISE_W'(neg_q ? (~div_q + 1'b1) : div_q);

	assign v      = $signed(sample_rd);
	assign nmx    = (i_q == '0 || v > mx_q) ? v : mx_q;
	assign nmn    = (i_q == '0 || v < mn_q) ? v : mn_q;
	assign spread = (SAMPLE_W+1)'(nmx) - (SAMPLE_W+1)'(nmn);

	assign ref_sh = $signed(ref_rd) >>> 8;
	assign filt   = (FILT_W+1)'(s_q) - (FILT_W+1)'(ref_sh);

	pis_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_q)
	);

	pis_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_PERIOD)) u_recent (
		.clk   (clk),
		.we    ((cmd.fill && k_low) || cmd.upd),
		.waddr (cmd.fill ? k_q[PW-1:0] : p_q),
		.wdata (cmd.fill ? fval : s_q),
		.raddr (cmd.use_j ? j_q : p_q),
		.rdata (recent_rd)
	);

	pis_ram #(.WIDTH(SAMPLE_W), .DEPTH(HD)) u_sample (
		.clk   (clk),
		.we    (cmd.fill || cmd.upd),
		.waddr (cmd.fill ? k_q : wr_sp),
		.wdata (cmd.fill ? fval : s_q),
		.raddr (rd_ij),
		.rdata (sample_rd)
	);

	pis_ram #(.WIDTH(NOISE_W), .DEPTH(HD)) u_noise (
		.clk   (clk),
		.we    (cmd.fill || cmd.noise_wr),
		.waddr (cmd.fill ? k_q : wr_sp),
		.wdata (cmd.fill ? '0 : qval),
		.raddr (rd_ij),
		.rdata (noise_rd)
	);

	pis_ram #(.WIDTH(NOISE_W), .DEPTH(MAX_PERIOD)) u_ref (
		.clk   (clk),
		.we    ((cmd.fill && k_low) || cmd.ref_wr),
		.waddr (cmd.fill ? k_q[PW-1:0] : j_q),
		.wdata (cmd.fill ? '0 : av_val),
		.raddr (p_q),
		.rdata (ref_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_len_q <= PLEN_RST;
			thr_q        <= THR_RST;
			rs_pend_q    <= 1'b0;
			phase_q      <= '0;
			slot_q       <= '0;
			sum_q        <= '0;
			lin_q        <= 1'b0;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			ovalid_q     <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_PERIOD_LEN) begin
				period_len_q <= cfg_data[LEN_W-1:0];
			end
			if (cfg_we && cfg_index == REG_THRESHOLD) begin
				thr_q <= cfg_data[THR_W-1:0];
			end
			if (cfg_we && cfg_index == REG_PERIOD_LEN) begin
				rs_pend_q <= 1'b1;
			end else if (cmd.rs_clr) begin
				rs_pend_q <= 1'b0;
			end

			if (cmd.reinit) begin
				sum_q   <= prod_q[SUM_W-1:0];
				phase_q <= '0;
				slot_q  <= '0;
			end else if (cmd.upd) begin
				sum_q <= sum_q + SUM_W'(s_q) - SUM_W'($signed(recent_rd));
			end else if (cmd.rs_clr) begin
				sum_q <= '0;
			end else if (cmd.rs_add) begin
				sum_q <= sum_q + SUM_W'($signed(recent_rd));
			end

			if (cmd.noise_wr) begin
				if (sts.period_end) begin
					phase_q <= '0;
					slot_q  <= (slot_q == SW'(NUM_PERIODS - 1)) ? '0 : slot_q + SW'(1);
				end else begin
					phase_q <= p_q + PW'(1);
				end
			end else if (cmd.phase_wrap && CW'(phase_q) >= CW'(len)) begin
				phase_q <= '0;
			end

			if (cmd.take) begin
				lin_q <= 1'b0;
			end else if (cmd.set_lin) begin
				lin_q <= 1'b1;
			end

			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + SW'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + PW'(1);
			end
			if (cmd.k_inc) begin
				k_q <= sts.k_last ? '0 : k_q + HAW'(1);
			end

			if (cmd.out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			s_q    <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
			kind_q <= s_axis_tuser[0];
			p_q    <= phase_q;
		end
		if (cmd.mul) begin
			prod_q <= (SUM_W+1)'($signed({1'b0, len}) * s_q);
		end
		if (cmd.noise_start) begin
			neg_q <= diff[SUM_W+1];
		end
		if (cmd.lc_upd) begin
			mx_q <= nmx;
			mn_q <= nmn;
		end
		if (cmd.av_add) begin
			acc_q <= ((i_q == '0) ? '0 : acc_q) + ACC_W'($signed(noise_rd));
		end
		if (cmd.out_load) begin
			filt_q <= FILT_W'(filt);
			olin_q <= lin_q;
		end
	end

	always_comb begin
		sts.kind       = kind_q;
		sts.rs_pend    = rs_pend_q;
		sts.div_busy   = div_busy;
		sts.k_last     = k_q == HAW'(HD - 1);
		sts.i_last     = i_q == SW'(NUM_PERIODS - 1);
		sts.j_last     = CW'(j_q) == CW'(len) - CW'(1);
		sts.period_end = CW'(p_q) + CW'(1) >= CW'(len);
		sts.spread_bad = $unsigned(spread) > (SAMPLE_W+1)'(thr_q);
		sts.out_free   = !ovalid_q || m_axis_tready;
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = TDATA_OUT_W'(filt_q);
	assign m_axis_tuser  = olin_q;

endmodule

// ===== design/pis_ctrl.sv =====
module pis_ctrl import pis_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	output cmd_t cmd,
	input  sts_t sts
);

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MUL,
		ST_FILL,
		ST_UPD,
		ST_NUM,
		ST_NDIV,
		ST_NWR,
		ST_LC_RD,
		ST_LC_CMP,
		ST_AV_RD,
		ST_AV_ACC,
		ST_AV_WR,
		ST_REF_RD,
		ST_OUT,
		ST_RS0,
		ST_RS_RD,
		ST_RS_ACC
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign s_axis_tready = (state_q == ST_IDLE) && !sts.rs_pend;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.fill      = 1'b1;
				cmd.fill_zero = 1'b1;
				cmd.k_inc     = 1'b1;
				if (sts.k_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (sts.rs_pend) begin
					state_nx = ST_RS0;
				end else if (s_axis_tvalid) begin
					cmd.take = 1'b1;
					state_nx = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul  = 1'b1;
				state_nx = (sts.kind == KIND_REINIT) ? ST_FILL : ST_UPD;
			end
			ST_FILL: begin
				cmd.fill   = 1'b1;
				cmd.reinit = 1'b1;
				cmd.k_inc  = 1'b1;
				if (sts.k_last) state_nx = ST_IDLE;
			end
			ST_UPD: begin
				cmd.upd  = 1'b1;
				state_nx = ST_NUM;
			end
			ST_NUM: begin
				cmd.noise_start = 1'b1;
				state_nx        = ST_NDIV;
			end
			ST_NDIV: begin
				if (!sts.div_busy) state_nx = ST_NWR;
			end
			ST_NWR: begin
				cmd.noise_wr = 1'b1;
				if (sts.period_end) begin
					cmd.i_clr = 1'b1;
					cmd.j_clr = 1'b1;
					state_nx  = ST_LC_RD;
				end else begin
					state_nx = ST_REF_RD;
				end
			end
			ST_LC_RD: begin
				state_nx = ST_LC_CMP;
			end
			ST_LC_CMP: begin
				cmd.lc_upd = 1'b1;
				if (!sts.i_last) begin
					cmd.i_inc = 1'b1;
					state_nx  = ST_LC_RD;
				end else if (sts.spread_bad) begin
					state_nx = ST_REF_RD;
				end else if (sts.j_last) begin
					cmd.set_lin = 1'b1;
					cmd.i_clr   = 1'b1;
					cmd.j_clr   = 1'b1;
					state_nx    = ST_AV_RD;
				end else begin
					cmd.i_clr = 1'b1;
					cmd.j_inc = 1'b1;
					state_nx  = ST_LC_RD;
				end
			end
			ST_AV_RD: begin
				state_nx = ST_AV_ACC;
			end
			ST_AV_ACC: begin
				cmd.av_add = 1'b1;
				if (sts.i_last) begin
					state_nx = ST_AV_WR;
				end else begin
					cmd.i_inc = 1'b1;
					state_nx  = ST_AV_RD;
				end
			end
			ST_AV_WR: begin
				cmd.ref_wr = 1'b1;
				if (sts.j_last) begin
					state_nx = ST_REF_RD;
				end else begin
					cmd.i_clr = 1'b1;
					cmd.j_inc = 1'b1;
					state_nx  = ST_AV_RD;
				end
			end
			ST_REF_RD: begin
				state_nx = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			ST_RS0: begin
				cmd.rs_clr = 1'b1;
				cmd.j_clr  = 1'b1;
				state_nx   = ST_RS_RD;
			end
			ST_RS_RD: begin
				cmd.use_j = 1'b1;
				state_nx  = ST_RS_ACC;
			end
			ST_RS_ACC: begin
				cmd.rs_add = 1'b1;
				if (sts.j_last) begin
					cmd.phase_wrap = 1'b1;
					state_nx       = ST_IDLE;
				end else begin
					cmd.j_inc = 1'b1;
					state_nx  = ST_RS_RD;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

// ===== design/powerline_interference_subtractor.sv =====
// Mains interference subtractor for ECG streams. Each sample (tuser 0) enters the
// moving-average noise estimate and leaves as one result: the sample minus the
// stored interference reference at its phase, with tuser set when that sample closed
// a mains period that passed the linearity test and refreshed the reference. A
// reinitialize item (tuser 1) fills the sample stores with its value, clears noise
// and reference, and produces no result. NUM_PERIODS must be a power of two; the
// block itself does not enforce this. The time per item is set by the controller
// walking the histories one entry at a time and by a 40-step restoring divider for
// the noise, and one item is handled at a time. A period end adds a spread check
// and, when the period is linear, reference averaging; a reinitialize fills every
// store entry, and a period_len write triggers a recompute of the running sum
// during which no sample is taken. After reset the block clears all stores before
// the first sample is taken.
module powerline_interference_subtractor import pis_pkg::*; #(
	parameter int MAX_PERIOD  = MAX_PERIOD_DEF,
	parameter int NUM_PERIODS = NUM_PERIODS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	input  logic [TDATA_IN_W-1:0]   s_axis_tdata,  // sample
	input  logic [0:0]              s_axis_tuser,  // kind
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	output logic [TDATA_OUT_W-1:0]  m_axis_tdata,  // filtered, zero pad
	output logic [0:0]              m_axis_tuser,  // period_linear
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data
);

	cmd_t cmd;
	sts_t sts;

	pis_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.cmd           (cmd),
		.sts           (sts)
	);

	pis_dp #(
		.MAX_PERIOD  (MAX_PERIOD),
		.NUM_PERIODS (NUM_PERIODS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

endmodule

// ===== design/pis_checker.sv =====
module pis_checker import pis_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    s_axis_tvalid,
	input logic                    s_axis_tready,
	input logic [TDATA_IN_W-1:0]   s_axis_tdata,
	input logic [0:0]              s_axis_tuser,
	input logic                    m_axis_tvalid,
	input logic                    m_axis_tready,
	input logic [TDATA_OUT_W-1:0]  m_axis_tdata,
	input logic [0:0]              m_axis_tuser,
	input logic                    cfg_we,
	input logic [CFG_IDX_W-1:0]    cfg_index,
	input logic [CFG_DATA_W-1:0]   cfg_data
);

	// one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input taken right after a transfer");

	// period length change recomputes the running sum before the next sample
	a_resync: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_PERIOD_LEN) |=> !s_axis_tready)
		else $error("input ready during running sum recompute");

	// reinitialize produces no result
	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser[0] == KIND_REINIT && !m_axis_tvalid)
		|=> !m_axis_tvalid)
		else $error("result after reinitialize");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready)
		|=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
		else $error("stalled result changed");

endmodule

bind powerline_interference_subtractor pis_checker u_pis_checker (.*);

// ===== tb/sv/powerline_interference_subtractor_checker.sv =====
`timescale 1ns / 1ps
module powerline_interference_subtractor_checker import pis_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	input  logic [TDATA_IN_W-1:0]   s_axis_tdata,
	input  logic [0:0]              s_axis_tuser,
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	input  logic [TDATA_OUT_W-1:0]  m_axis_tdata,
	input  logic [0:0]              m_axis_tuser,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output int                      errors,
	output int                      outstanding
);
	localparam int MAXP = MAX_PERIOD_DEF;
	localparam int NPER = NUM_PERIODS_DEF;

	typedef struct {
		logic [TDATA_OUT_W-1:0] filtered;
		logic                   linear;
	} clean_t;

	clean_t clean_q[$];

	logic [LEN_W-1:0] plen;
	logic [THR_W-1:0] thr;
	longint last_per[MAXP];
	longint win_sum;
	longint raw_hist[NPER*MAXP];
	longint hum_hist[NPER*MAXP];
	longint hum_ref[MAXP];
	int     phase;
	int     slot;

	function automatic int eff_len();
		int l;
		l = plen;
		if (l < 2) l = 2;
		if (l > MAXP) l = MAXP;
		return l;
	endfunction

	task automatic clear_state();
		plen = PLEN_RST;
		thr = THR_RST;
		win_sum = 0;
		phase = 0;
		slot = 0;
		for (int i = 0; i < MAXP; i++) begin
			last_per[i] = 0;
			hum_ref[i] = 0;
		end
		for (int i = 0; i < NPER*MAXP; i++) begin
			raw_hist[i] = 0;
			hum_hist[i] = 0;
		end
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		int l;
		if (idx == REG_PERIOD_LEN) begin
			plen = val[LEN_W-1:0];
			l = eff_len();
			win_sum = 0;
			for (int i = 0; i < l; i++) win_sum += last_per[i];
			if (phase >= l) phase = 0;
		end else if (idx == REG_THRESHOLD) begin
			thr = val;
		end
	endtask

	task automatic subtract_hum(logic kind, longint s);
		int l, p;
		longint hum, mx, mn, acc, filt;
		bit lin;
		clean_t c;
		l = eff_len();
		lin = 0;
		if (kind == KIND_REINIT) begin
			for (int i = 0; i < MAXP; i++) begin
				last_per[i] = s;
				hum_ref[i] = 0;
			end
			for (int i = 0; i < NPER*MAXP; i++) begin
				raw_hist[i] = s;
				hum_hist[i] = 0;
			end
			win_sum = l * s;
			phase = 0;
			slot = 0;
			return;
		end
		if (phase >= l) phase = 0;
		if (slot >= NPER) slot = 0;
		p = phase;
		raw_hist[slot*MAXP + p] = s;
		win_sum += s - last_per[p];
		last_per[p] = s;
		hum = ((l * s - win_sum) * 256) / l;
		hum_hist[slot*MAXP + p] = hum;
		phase = p + 1;
		if (phase >= l) begin
			phase = 0;
			slot = (slot + 1) % NPER;
			lin = 1;
			for (int j = 0; j < l && lin; j++) begin
				mx = raw_hist[j];
				mn = raw_hist[j];
				for (int i = 1; i < NPER; i++) begin
					if (raw_hist[i*MAXP + j] > mx) mx = raw_hist[i*MAXP + j];
					if (raw_hist[i*MAXP + j] < mn) mn = raw_hist[i*MAXP + j];
				end
				if (mx - mn > longint'(thr)) lin = 0;
			end
			if (lin) begin
				for (int j = 0; j < l; j++) begin
					acc = 0;
					for (int i = 0; i < NPER; i++) acc += hum_hist[i*MAXP + j];
					hum_ref[j] = acc / NPER;
				end
			end
		end
		filt = s - (hum_ref[p] >>> 8);
		c.filtered = TDATA_OUT_W'(filt[FILT_W-1:0]);
		c.linear = lin;
		clean_q.push_back(c);
	endtask

	always @(posedge clk or negedge arst_n) begin
		clean_t c;
		if (!arst_n) begin
			clear_state();
			clean_q.delete();
			errors <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (clean_q.size() == 0) begin
					$display("%0t: unexpected result expected none actual %h/%b",
						$time, m_axis_tdata, m_axis_tuser);
					errors <= errors + 1;
				end else begin
					c = clean_q.pop_front();
					if (m_axis_tdata !== c.filtered || m_axis_tuser[0] !== c.linear) begin
						$display("%0t: mismatch filtered expected %h actual %h, linear expected %b actual %b",
							$time, c.filtered, m_axis_tdata, c.linear, m_axis_tuser[0]);
						errors <= errors + 1;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				subtract_hum(s_axis_tuser[0], longint'($signed(s_axis_tdata)));
			if (cfg_we)
				write_reg(cfg_index, cfg_data);
		end
	end

	assign outstanding = clean_q.size();
endmodule

// ===== tb/sv/powerline_interference_subtractor_tb.sv =====
`timescale 1ns / 1ps
module powerline_interference_subtractor_tb;
	import pis_pkg::*;

	localparam int SETTLE = 8000;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [TDATA_IN_W-1:0]  s_axis_tdata;   // sample
	logic [0:0]             s_axis_tuser;   // kind
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;   // filtered, zero pad
	logic [0:0]             m_axis_tuser;   // period_linear
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	int                     errors;
	int                     outstanding;

	bit quiet;
	bit hold_req;
	int cur_len;
	int rr_base;
	int jit;
	int wave[128];

	powerline_interference_subtractor DUT (.*);
	powerline_interference_subtractor_checker chk (.*);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	// result side stalls
	initial begin
		int n;
		m_axis_tready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_req = 0;
			end
			n = quiet ? 0 : $urandom_range(0, 16);
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	task automatic push_item(logic kind, int val);
		int n;
		n = quiet ? 0 : $urandom_range(0, 16);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= TDATA_IN_W'(val);
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_regs(int plen, int thr);
		int l;
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_PERIOD_LEN;
		cfg_data <= CFG_DATA_W'(plen);
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_data <= CFG_DATA_W'(thr);
		@(posedge clk);
		cfg_we <= 1'b0;
		l = plen & 255;
		cur_len = l < 2 ? 2 : (l > 128 ? 128 : l);
		rr_base = $urandom_range(0, 8000000) - 4000000;
		jit = $urandom_range(0, 1) ? 0 : (thr > 4 ? thr / 3 : 1);
		for (int i = 0; i < 128; i++) wave[i] = $urandom_range(0, 1000) - 500;
	endtask

	task automatic random_items(int count);
		int pos;
		int r;
		pos = 0;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				push_item(KIND_REINIT, rr_base + $urandom_range(0, 200));
				pos = 0;
			end else if (r < 15) begin
				push_item(KIND_SAMPLE, int'($urandom));
				pos++;
			end else begin
				push_item(KIND_SAMPLE, rr_base + wave[pos % cur_len] +
					(jit > 0 ? $urandom_range(0, jit) : 0));
				pos++;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		quiet = 0;
		hold_req = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_item(KIND_REINIT, 8388607);
		push_item(KIND_SAMPLE, -8388608);
		push_item(KIND_SAMPLE, 8388607);
		push_item(KIND_REINIT, 1000);
		for (int i = 0; i < 20; i++) push_item(KIND_SAMPLE, 1000 + $urandom_range(0, 30));
		push_item(KIND_SAMPLE, 0);

		set_regs(2, 0);
		random_items(25);
		set_regs(128, 131071);
		random_items(135);
		set_regs(0, 50);
		quiet = 1;
		random_items(20);
		quiet = 0;
		set_regs(255, 3000);
		random_items(10);
		set_regs(9, 100000);
		hold_req = 1;
		random_items(30);
		set_regs(1, 1);
		random_items(10);
		set_regs(5, 200);
		random_items(20);
		set_regs(20, 100);
		random_items(15);

		drain();
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// ===== files.f =====
design/pis_pkg.sv
design/pis_ram.sv
design/pis_div.sv
design/pis_dp.sv
design/pis_ctrl.sv
design/powerline_interference_subtractor.sv
design/pis_checker.sv
tb/sv/powerline_interference_subtractor_checker.sv
tb/sv/powerline_interference_subtractor_tb.sv
